>>> sv/bqf_pkg.sv
// shared types and constants for the four-channel biquad filter
// no dependencies; imported by bqf_ctrl, bqf_datapath and the top level
package bqf_pkg;

  localparam int COEF_W     = 24;   // coefficient width, Q4.20
  localparam int COEF_FRAC  = 20;   // coefficient fraction bits
  localparam int NUM_COEFS  = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CH_W       = 2;    // channel field width
  localparam int STATE_W    = 32;   // delay state width
  localparam int PROD_W     = STATE_W + COEF_W;
  localparam int ACC_W      = 60;   // exact sum of products and scaled state
  localparam int RQ_W       = ACC_W - COEF_FRAC;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_F0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_F1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_F2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd4;

  // operand pair for the shared multiplier
  typedef enum logic [2:0] {
    MUL_F0X,
    MUL_F1X,
    MUL_F2X,
    MUL_B1Y,
    MUL_B2Y
  } bqf_mul_sel_t;

  // accumulator operation
  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD_Z1,
    ACC_ADD,
    ACC_LOAD_Z2,
    ACC_SUB,
    ACC_LOAD_PROD
  } bqf_acc_op_t;

  typedef struct packed {
    logic         latch_in;
    bqf_mul_sel_t mul_sel;
    bqf_acc_op_t  acc_op;
    logic         y_load;
    logic         z1_wr;
    logic         z2_wr;
    logic         out_load;
  } bqf_cmd_t;

  typedef struct packed {
    logic out_free;
  } bqf_stat_t;

endpackage

>>> sv/bqf_ctrl.sv
// sequencer for the biquad: steps one request at a time through the datapath
// depends on bqf_pkg
module bqf_ctrl
  import bqf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  bqf_stat_t stat,
  output bqf_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_C1,
    S_C2,
    S_C3,
    S_C4,
    S_C5,
    S_C6,
    S_C7,
    S_C8
  } state_t;

  state_t state_r;
  logic   in_stall_r;

  assign in_stall = in_stall_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r    <= S_C1;
            in_stall_r <= 1'b1;
          end
        end
        S_C1: state_r <= S_C2;
        S_C2: state_r <= S_C3;
        S_C3: state_r <= S_C4;
        S_C4: state_r <= S_C5;
        S_C5: state_r <= S_C6;
        S_C6: state_r <= S_C7;
        S_C7: state_r <= S_C8;
        S_C8: begin
          if (stat.out_free) begin
            state_r    <= S_IDLE;
            in_stall_r <= 1'b0;
          end
        end
        default: begin
          state_r    <= S_IDLE;
          in_stall_r <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd.latch_in = 1'b0;
    cmd.mul_sel  = MUL_F0X;
    cmd.acc_op   = ACC_HOLD;
    cmd.y_load   = 1'b0;
    cmd.z1_wr    = 1'b0;
    cmd.z2_wr    = 1'b0;
    cmd.out_load = 1'b0;
    unique case (state_r)
      S_IDLE: cmd.latch_in = in_valid;
      S_C1: begin
        cmd.mul_sel = MUL_F0X;
        cmd.acc_op  = ACC_LOAD_Z1;
      end
      S_C2: begin
        cmd.mul_sel = MUL_F1X;
        cmd.acc_op  = ACC_ADD;
      end
      S_C3: begin
        cmd.y_load = 1'b1;
        cmd.acc_op = ACC_LOAD_Z2;
      end
      S_C4: cmd.mul_sel = MUL_B1Y;
      S_C5: begin
        cmd.mul_sel = MUL_F2X;
        cmd.acc_op  = ACC_SUB;
      end
      S_C6: begin
        cmd.z1_wr   = 1'b1;
        cmd.mul_sel = MUL_B2Y;
        cmd.acc_op  = ACC_LOAD_PROD;
      end
      S_C7: cmd.acc_op = ACC_SUB;
      S_C8: begin
        cmd.z2_wr    = stat.out_free;
        cmd.out_load = stat.out_free;
      end
      default: cmd.latch_in = 1'b0;
    endcase
  end

endmodule

>>> sv/bqf_datapath.sv
// biquad datapath: coefficients, per-channel delay states, shared multiplier,
// accumulator with rounding and saturation, output register; depends on bqf_pkg
module bqf_datapath
  import bqf_pkg::*;
#(
  parameter int CHANNELS     = 4,
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [COEF_W-1:0]              cfg_wdata,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_in,
  input  logic [CH_W-1:0]                in_channel,
  input  logic                           in_block_last,
  input  bqf_cmd_t                       cmd,
  output bqf_stat_t                      stat,
  input  logic                           out_stall,
  output logic                           out_valid,
  output logic signed [SAMPLE_WIDTH-1:0] out_sample_out,
  output logic [CH_W-1:0]                out_channel_out,
  output logic                           out_block_last_out
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (COEF_FRAC - 1);

  logic signed [COEF_W-1:0]       coef_f0_r, coef_f1_r, coef_f2_r, coef_b1_r, coef_b2_r;
  logic signed [STATE_W-1:0]      z1_r [CHANNELS];
  logic signed [STATE_W-1:0]      z2_r [CHANNELS];
  logic signed [SAMPLE_WIDTH-1:0] x_r;
  logic [CH_W-1:0]                ch_r;
  logic                           last_r;
  logic                           ch_ok_r;
  logic [IDX_W-1:0]               idx;
  logic signed [STATE_W-1:0]      z1_rd, z2_rd;
  logic signed [STATE_W-1:0]      x_ext;
  logic signed [STATE_W-1:0]      y_r;
  logic signed [STATE_W-1:0]      op_a;
  logic signed [COEF_W-1:0]       op_b;
  logic signed [PROD_W-1:0]       prod_nxt, prod_r;
  logic signed [ACC_W-1:0]        acc_r, acc_nxt;
  logic [ACC_W-1:0]               rnd_sum;
  logic signed [RQ_W-1:0]         rnd_q;
  logic signed [STATE_W-1:0]      rnd_sat;
  logic signed [SAMPLE_WIDTH-1:0] y_sat;
  logic                           out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_r;
  logic [CH_W-1:0]                out_ch_r;
  logic                           out_last_r;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_f0_r <= '0;
      coef_f1_r <= '0;
      coef_f2_r <= '0;
      coef_b1_r <= '0;
      coef_b2_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_F0:  coef_f0_r <= cfg_wdata;
        REG_F1:  coef_f1_r <= cfg_wdata;
        REG_F2:  coef_f2_r <= cfg_wdata;
        REG_B1:  coef_b1_r <= cfg_wdata;
        REG_B2:  coef_b2_r <= cfg_wdata;
        default: coef_f0_r <= coef_f0_r;  // unknown index ignored
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      x_r     <= in_sample_in;
      ch_r    <= in_channel;
      last_r  <= in_block_last;
      ch_ok_r <= (int'(in_channel) < CHANNELS);
    end
  end

  assign idx   = IDX_W'(ch_r);
  assign z1_rd = ch_ok_r ? z1_r[idx] : '0;
  assign z2_rd = ch_ok_r ? z2_r[idx] : '0;
  assign x_ext = STATE_W'(x_r);

  // shared multiplier, registered product
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_F0X: begin op_a = x_ext; op_b = coef_f0_r; end
      MUL_F1X: begin op_a = x_ext; op_b = coef_f1_r; end
      MUL_F2X: begin op_a = x_ext; op_b = coef_f2_r; end
      MUL_B1Y: begin op_a = y_r;   op_b = coef_b1_r; end
      MUL_B2Y: begin op_a = y_r;   op_b = coef_b2_r; end
      default: begin op_a = x_ext; op_b = coef_f0_r; end
    endcase
  end

  assign prod_nxt = op_a * op_b;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // accumulator
  always_comb begin
    unique case (cmd.acc_op)
      ACC_HOLD:      acc_nxt = acc_r;
      ACC_LOAD_Z1:   acc_nxt = ACC_W'(z1_rd) <<< COEF_FRAC;
      ACC_ADD:       acc_nxt = acc_r + ACC_W'(prod_r);
      ACC_LOAD_Z2:   acc_nxt = (ACC_W'(z2_rd) <<< COEF_FRAC) + ACC_W'(prod_r);
      ACC_SUB:       acc_nxt = acc_r - ACC_W'(prod_r);
      ACC_LOAD_PROD: acc_nxt = ACC_W'(prod_r);
      default:       acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // round half up, then saturate to the state width
  assign rnd_sum = acc_r + ROUND_BIAS;
  assign rnd_q   = rnd_sum[ACC_W-1:COEF_FRAC];

  always_comb begin
    if ((&rnd_q[RQ_W-1:STATE_W-1]) || !(|rnd_q[RQ_W-1:STATE_W-1])) begin
      rnd_sat = rnd_q[STATE_W-1:0];
    end else if (rnd_q[RQ_W-1]) begin
      rnd_sat = {1'b1, {(STATE_W-1){1'b0}}};
    end else begin
      rnd_sat = {1'b0, {(STATE_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.y_load) begin
      y_r <= rnd_sat;
    end
  end

  // delay states
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        z1_r[i] <= '0;
        z2_r[i] <= '0;
      end
    end else begin
      if (cmd.z1_wr && ch_ok_r) begin
        z1_r[idx] <= rnd_sat;
      end
      if (cmd.z2_wr && ch_ok_r) begin
        z2_r[idx] <= rnd_sat;
      end
    end
  end

  // output saturation to sample width
  always_comb begin
    if ((&y_r[STATE_W-1:SAMPLE_WIDTH-1]) || !(|y_r[STATE_W-1:SAMPLE_WIDTH-1])) begin
      y_sat = y_r[SAMPLE_WIDTH-1:0];
    end else if (y_r[STATE_W-1]) begin
      y_sat = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_sample_r <= ch_ok_r ? y_sat : '0;
      out_ch_r     <= ch_r;
      out_last_r   <= last_r;
    end
  end

  assign stat.out_free      = !out_valid_r || !out_stall;
  assign out_valid          = out_valid_r;
  assign out_sample_out     = out_sample_r;
  assign out_channel_out    = out_ch_r;
  assign out_block_last_out = out_last_r;

endmodule

>>> sv/four_channel_biquad_filter.sv
// top level of the four-channel biquad filter (transposed direct form II)
// depends on bqf_pkg, bqf_ctrl and bqf_datapath
//
// usage
//   input channel: in_valid / in_stall with in_sample_in, in_channel and
//   in_block_last; a request is taken at a clock edge with in_valid high and
//   in_stall low. each request gives exactly one result on the output channel
//   (out_valid / out_stall), in request order, channel and block-last copied.
//   coefficients f0, f1, f2, b1, b2 (signed q4.20) are written through cfg_we /
//   cfg_index / cfg_wdata; the user must write them only while no request is
//   in flight, not enforced by the block; an index past b2 is ignored. a channel
//   number at or above CHANNELS gives a zero sample, delay states untouched.
// timing
//   one 32x24 multiplier and one accumulator are shared by the five products,
//   stepped by the controller through eight steps; one request is in flight
//   at a time, so a new request is taken only once the last result is loaded.
//   in_stall is high from the request edge until the result is loaded.
//   the result sits in an output register, so the next request can be taken
//   while it waits; if that register is still held by out_stall when the next
//   result is ready, the sequencer holds in its last step until it frees up.
// reset
//   synchronous active-low rst_n clears coefficients, all delay states and
//   the output valid flag; the block is ready for a request right after reset
module four_channel_biquad_filter
  import bqf_pkg::*;
#(
  parameter int CHANNELS     = 4,
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [COEF_W-1:0]              cfg_wdata,
  // input requests
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_in,
  input  logic [CH_W-1:0]                in_channel,
  input  logic                           in_block_last,
  // results
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_sample_out,
  output logic [CH_W-1:0]                out_channel_out,
  output logic                           out_block_last_out
);

  bqf_cmd_t  cmd;   // controller -> datapath step commands
  bqf_stat_t stat;  // datapath -> controller output-slot status

  // sequencer: one request at a time, eight steps each
  bqf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // arithmetic, state and output register
  bqf_datapath #(
    .CHANNELS     (CHANNELS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_sample_in       (in_sample_in),
    .in_channel         (in_channel),
    .in_block_last      (in_block_last),
    .cmd                (cmd),
    .stat               (stat),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_sample_out     (out_sample_out),
    .out_channel_out    (out_channel_out),
    .out_block_last_out (out_block_last_out)
  );

`ifndef NO_ASSERTIONS
  // a taken request closes the input: in_stall is high after the request edge
  a_stall_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after request");

  // results are only loaded while a request is in flight
  a_load_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> in_stall)
    else $error("result loaded with no request in flight");

  // the two delay states are never written in the same step
  a_delay_wr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.z1_wr && cmd.z2_wr))
    else $error("both delay states written at once");

  // a loaded result shows up on the output next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("loaded result not presented");
`endif

endmodule
